// File: rtl/assert_macros.svh
// assertion macros shared by the checker files
// no dependencies; take in with an include of the bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition that must hold at every edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/pps_pkg.sv
// constants, codes and pipeline types of the pwm prescaler and period solver
// no dependencies; imported by every module of the block
`default_nettype none

package pps_pkg;

  localparam logic [31:0] CLOCK_RESET = 32'd72000000;

  // counter limit: prescale divisor and period both fit a 16-bit counter
  localparam int          CNT_W       = 16;
  localparam logic [15:0] COUNTER_MAX = 16'hffff;

  localparam logic [15:0] FINE_MIN   = 16'd1000;
  localparam logic [15:0] COARSE_MIN = 16'd100;
  localparam logic [9:0]  DUTY_FULL  = 10'd1000;

  // floor(x/25) = (x * RECIP25) >> RECIP25_SHIFT for x < 2^30
  localparam logic [30:0] RECIP25       = 31'd1374389535;
  localparam int          RECIP25_SHIFT = 35;
  // floor(x/1000) = (x * RECIP1000) >> RECIP1000_SHIFT for x < 2^26
  localparam logic [26:0] RECIP1000       = 27'd68719477;
  localparam int          RECIP1000_SHIFT = 36;

  localparam int DIV1_STEPS = 32;
  localparam int DIV2_STEPS = 16;

  typedef enum logic [1:0] {
    STATUS_FINE   = 2'd0,
    STATUS_COARSE = 2'd1,
    STATUS_FAILED = 2'd2
  } status_t;

  // restoring division working set
  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] num;
    logic [31:0] quo;
    logic [31:0] den;
  } div_t;

  typedef struct packed {
    logic [9:0] duty;
    logic       clamped;
    logic       fail;
  } side_t;

  typedef struct packed {
    logic  valid;
    div_t  dv;
    side_t sd;
  } stage_t;

endpackage

`default_nettype wire

// File: rtl/pps_if.sv
// request and response channel interfaces of the pwm prescaler and period solver
// no dependencies
`default_nettype none

interface pps_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] freq_hz;
  logic [9:0]  duty_permille;

  modport source (output valid, output freq_hz, output duty_permille, input ready);
  modport sink (input valid, input freq_hz, input duty_permille, output ready);
endinterface

interface pps_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] prescale_div;
  logic [15:0] period_count;
  logic [15:0] pulse_count;
  logic [1:0]  resolution_status;
  logic        freq_clamped;

  modport source (output valid, output prescale_div, output period_count,
                  output pulse_count, output resolution_status, output freq_clamped,
                  input ready);
  modport sink (input valid, input prescale_div, input period_count,
                input pulse_count, input resolution_status, input freq_clamped,
                output ready);
endinterface

`default_nettype wire

// File: rtl/pps_front.sv
// front end: duty saturation, clock/100 limit, frequency clamp, divider set-up
// depends on pps_pkg and pps_in_if
`default_nettype none

module pps_front import pps_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  en,
  pps_in_if.sink     req,
  input  wire logic [31:0] timer_clock_hz,
  output stage_t     q
);

  logic [60:0] lim_prod;
  logic [9:0]  duty_sat;

  logic        v1;
  logic [31:0] freq1;
  logic [9:0]  duty1;
  logic [31:0] clk1;
  logic [25:0] lim1;

  logic        clamped;
  logic [31:0] freq_eff;

  // clock/100 as (clock/4)/25 by reciprocal
  assign lim_prod = 61'(timer_clock_hz[31:2]) * 61'(RECIP25);
  assign duty_sat = (req.duty_permille > DUTY_FULL) ? DUTY_FULL : req.duty_permille;

  always_ff @(posedge clk) begin
    if (en) begin
      freq1 <= req.freq_hz;
      duty1 <= duty_sat;
      clk1  <= timer_clock_hz;
      lim1  <= lim_prod[RECIP25_SHIFT +: 26];
    end
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= req.valid;
    end
  end

  assign clamped  = freq1 > {6'd0, lim1};
  assign freq_eff = clamped ? {6'd0, lim1} : freq1;

  always_ff @(posedge clk) begin
    if (en) begin
      q.dv.rem     <= '0;
      q.dv.num     <= clk1;
      q.dv.quo     <= '0;
      q.dv.den     <= freq_eff;
      q.sd.duty    <= duty1;
      q.sd.clamped <= clamped;
      q.sd.fail    <= (freq_eff == 32'd0);
    end
    if (rst) begin
      q.valid <= 1'b0;
    end else if (en) begin
      q.valid <= v1;
    end
  end

endmodule

`default_nettype wire

// File: rtl/pps_div_step.sv
// one stage of the pipelined restoring divider: one quotient bit per stage
// depends on pps_pkg
`default_nettype none

module pps_div_step import pps_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic en,
  input  stage_t    d,
  output stage_t    q
);

  logic [32:0] trial;
  logic [32:0] diff;
  logic        ge;

  assign trial = {d.dv.rem, d.dv.num[31]};
  assign diff  = trial - {1'b0, d.dv.den};
  assign ge    = trial >= {1'b0, d.dv.den};

  always_ff @(posedge clk) begin
    if (en) begin
      q.dv.rem <= ge ? diff[31:0] : trial[31:0];
      q.dv.num <= {d.dv.num[30:0], 1'b0};
      q.dv.quo <= {d.dv.quo[30:0], ge};
      q.dv.den <= d.dv.den;
      q.sd     <= d.sd;
    end
    if (rst) begin
      q.valid <= 1'b0;
    end else if (en) begin
      q.valid <= d.valid;
    end
  end

endmodule

`default_nettype wire

// File: rtl/pps_back.sv
// back end: grading, pulse = floor(duty*period/1000), output register
// depends on pps_pkg and pps_out_if
`default_nettype none

module pps_back import pps_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic en,
  input  stage_t    d,
  pps_out_if.source rsp
);

  logic [15:0] per;
  status_t     grade;
  logic [25:0] prod_c;

  logic        v1;
  logic [15:0] div1;
  logic [15:0] per1;
  status_t     st1;
  logic [25:0] prod1;
  logic        clamped1;

  logic        v2;
  logic [15:0] div2;
  logic [15:0] per2;
  status_t     st2;
  logic [52:0] scaled2;
  logic        clamped2;

  logic        ok;

  assign per    = d.dv.quo[CNT_W-1:0];
  assign prod_c = 26'(d.sd.duty) * 26'(per);

  always_comb begin
    if (d.sd.fail) begin
      grade = STATUS_FAILED;
    end else if (per >= FINE_MIN) begin
      grade = STATUS_FINE;
    end else if (per >= COARSE_MIN) begin
      grade = STATUS_COARSE;
    end else begin
      grade = STATUS_FAILED;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      div1     <= d.dv.den[CNT_W-1:0];
      per1     <= per;
      st1      <= grade;
      prod1    <= prod_c;
      clamped1 <= d.sd.clamped;
      div2     <= div1;
      per2     <= per1;
      st2      <= st1;
      scaled2  <= 53'(prod1) * 53'(RECIP1000);
      clamped2 <= clamped1;
    end
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (en) begin
      v1 <= d.valid;
      v2 <= v1;
    end
  end

  assign ok = (st2 != STATUS_FAILED);

  // output register
  always_ff @(posedge clk) begin
    if (en) begin
      rsp.prescale_div      <= ok ? div2 : '0;
      rsp.period_count      <= ok ? per2 : '0;
      rsp.pulse_count       <= ok ? scaled2[RECIP1000_SHIFT +: 16] : '0;
      rsp.resolution_status <= st2;
      rsp.freq_clamped      <= clamped2;
    end
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (en) begin
      rsp.valid <= v2;
    end
  end

endmodule

`default_nettype wire

// File: rtl/pwm_prescaler_period_solver.sv
// top level of the pwm prescaler and period solver
// depends on pps_pkg, pps_if, pps_front, pps_div_step and pps_back
`default_nettype none

// Solves timer prescale divisor, period and compare value for a requested
// pwm frequency and duty (tenths of a percent) against the timer clock held
// in the one configuration register (reset 72 MHz). The frequency is limited
// to clock/100; ratio = clock/freq is found by a 32-stage restoring divider,
// the divisor is (ratio >> 16) + 1 and the period ratio/divisor comes from a
// second, 16-stage divider; periods of 1000 and above grade fine, 100 and
// above coarse, anything else (and a zero frequency or limit, or a ratio
// of 0xffff0000 or more, whose divisor would not fit) fails with all counts
// zero. The pulse is floor(duty*period/1000) by a reciprocal multiply.
// Throughput is one item per clock while rsp is not stalled. There are 53
// register stages: 2 front stages, 32 + 16 divider stages (one quotient bit
// per stage) and 3 back stages including the output register. The accepting
// edge loads the first of them. A stalled result freezes the whole pipeline,
// so req.ready follows rsp.ready whenever a result is waiting. Write the
// clock register only when no item is in flight.

module pwm_prescaler_period_solver import pps_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [31:0] cfg_wr_data,
  pps_in_if.sink           req,
  pps_out_if.source        rsp
);

  logic [31:0] timer_clock_hz;
  logic        en;

  stage_t s1 [0:DIV1_STEPS];
  stage_t s2 [0:DIV2_STEPS];

  logic [15:0] ratio_hi;
  logic [16:0] div_trial;
  logic        no_fit;

  // clock register
  always_ff @(posedge clk) begin
    if (rst) begin
      timer_clock_hz <= CLOCK_RESET;
    end else if (cfg_wr_en) begin
      timer_clock_hz <= cfg_wr_data;
    end
  end

  // whole pipeline advances unless the output register holds an untaken item
  assign en        = !rsp.valid || rsp.ready;
  assign req.ready = en;

  pps_front u_front (
    .clk            (clk),
    .rst            (rst),
    .en             (en),
    .req            (req),
    .timer_clock_hz (timer_clock_hz),
    .q              (s1[0])
  );

  // ratio = clock / limited frequency
  for (genvar i = 0; i < DIV1_STEPS; i++) begin : g_div1
    pps_div_step u_step (
      .clk (clk),
      .rst (rst),
      .en  (en),
      .d   (s1[i]),
      .q   (s1[i+1])
    );
  end

  // divisor = ratio/65536 + 1; the high half of ratio is already the
  // partial remainder for the period division, so only 16 bits remain
  assign ratio_hi  = s1[DIV1_STEPS].dv.quo[31:CNT_W];
  assign div_trial = {1'b0, ratio_hi} + 17'd1;
  assign no_fit    = (ratio_hi == COUNTER_MAX);

  always_comb begin
    s2[0]         = s1[DIV1_STEPS];
    s2[0].dv.rem  = {16'd0, ratio_hi};
    s2[0].dv.num  = {s1[DIV1_STEPS].dv.quo[CNT_W-1:0], 16'd0};
    s2[0].dv.quo  = '0;
    s2[0].dv.den  = {15'd0, div_trial};
    s2[0].sd.fail = s1[DIV1_STEPS].sd.fail || no_fit;
  end

  // period = ratio / divisor
  for (genvar j = 0; j < DIV2_STEPS; j++) begin : g_div2
    pps_div_step u_step (
      .clk (clk),
      .rst (rst),
      .en  (en),
      .d   (s2[j]),
      .q   (s2[j+1])
    );
  end

  pps_back u_back (
    .clk (clk),
    .rst (rst),
    .en  (en),
    .d   (s2[DIV2_STEPS]),
    .rsp (rsp)
  );

endmodule

`default_nettype wire

// File: rtl/pps_checker.sv
// port-level checker for the pwm prescaler and period solver, bound to the top
// depends on pps_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module pps_checker import pps_pkg::*; (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        rsp_valid,
  input wire logic        rsp_ready,
  input wire logic [15:0] prescale_div,
  input wire logic [15:0] period_count,
  input wire logic [15:0] pulse_count,
  input wire logic [1:0]  resolution_status,
  input wire logic        freq_clamped
);

  logic failed;
  logic fine;

  assign failed = (resolution_status == STATUS_FAILED);
  assign fine   = (resolution_status == STATUS_FINE);

  `ASSERT_NEXT(a_stall_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(prescale_div) && $stable(period_count) && $stable(pulse_count) && $stable(resolution_status) && $stable(freq_clamped), "stalled item changed")
  `ASSERT_IMPLIES(a_fail_zero, clk, rst, rsp_valid && failed, prescale_div == 16'd0 && period_count == 16'd0 && pulse_count == 16'd0, "failed item carries counts")
  `ASSERT_IMPLIES(a_ok_bounds, clk, rst, rsp_valid && !failed, prescale_div != 16'd0 && period_count >= COARSE_MIN && pulse_count <= period_count, "solved item out of bounds")
  `ASSERT_IMPLIES(a_grade, clk, rst, rsp_valid && !failed, fine == (period_count >= FINE_MIN), "grade disagrees with period")

endmodule

bind pwm_prescaler_period_solver pps_checker u_pps_checker (
  .clk               (clk),
  .rst               (rst),
  .rsp_valid         (rsp.valid),
  .rsp_ready         (rsp.ready),
  .prescale_div      (rsp.prescale_div),
  .period_count      (rsp.period_count),
  .pulse_count       (rsp.pulse_count),
  .resolution_status (rsp.resolution_status),
  .freq_clamped      (rsp.freq_clamped)
);

`default_nettype wire
